[design/e2c_pkg.sv]
// Shared types, constants and calendar helpers for the epoch seconds to calendar block.
// Used by e2c_ctrl, e2c_dpath and the top level epoch_seconds_to_calendar.
package e2c_pkg;

  // Stream widths: input is the raw seconds count, output packs eight fields into six bytes.
  localparam int unsigned InW  = 32;
  localparam int unsigned OutW = 48;

  // Constant divisions by reciprocal multiplication: quotient = (x * Recip) >> shift.
  // Seconds per day are 675 << 7 and sixty is 15 << 2, so the low bits bypass the product.
  localparam logic [25:0] RecipDay  = 26'd50903317;  // ceil(2^35 / 675), x below 2^25
  localparam logic [25:0] RecipMin  = 26'd34953;     // ceil(2^19 / 15), x below 2^15
  localparam logic [25:0] RecipHour = 26'd547;       // ceil(2^13 / 15), x below 2^9
  localparam logic [25:0] RecipWday = 26'd74899;     // ceil(2^19 / 7), x below 2^16
  localparam logic [9:0]  DenDay    = 10'd675;
  localparam logic [9:0]  DenSixty  = 10'd15;
  localparam logic [9:0]  DenWeek   = 10'd7;

  // Weekday of the epoch origin (a Thursday) and its year counted from 1900.
  localparam logic [15:0] EpochWday = 16'd4;
  localparam logic [7:0]  EpochYear = 8'd70;
  localparam logic [3:0]  LastMonth = 4'd11;

  // Which division the shared divider runs.
  typedef enum logic [1:0] {
    OP_DAY  = 2'd0,
    OP_MIN  = 2'd1,
    OP_HOUR = 2'd2,
    OP_WDAY = 2'd3
  } div_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    div_start;
    div_op_e div_op;
    logic    year_init;
    logic    year_step;
    logic    month_init;
    logic    month_step;
    logic    out_load;
  } e2c_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic year_done;
    logic month_done;
    logic out_free;
  } e2c_sts_t;

  // Leap test on a year counted from 1900. Within 1900..2155 only 1900 and 2100
  // are centuries that are not leap; 2000 is divisible by 400 and stays leap.
  function automatic logic is_leap(input logic [7:0] yr);
    is_leap = (yr[1:0] == 2'b00) && (yr != 8'd0) && (yr != 8'd200);
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    year_len = leap ? 9'd366 : 9'd365;
  endfunction

  // Month lengths, February depending on the leap flag.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    unique case (mon) inside
      4'd1:                     month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
      default:                  month_len = 5'd31;
    endcase
  endfunction

endpackage

[design/e2c_dpath.sv]
// Datapath: shared reciprocal divider, year and month walk registers and the output register.
// Depends on e2c_pkg for the command and status structs and the calendar helpers.
module e2c_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [e2c_pkg::InW-1:0]    in_data_i,   // epoch_seconds
  input  e2c_pkg::e2c_cmd_t          cmd_i,
  output e2c_pkg::e2c_sts_t          sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [e2c_pkg::OutW-1:0]   out_data_o
);
  import e2c_pkg::*;

  // Divider state: operand, low bits that bypass the product, operation, steps left.
  logic [24:0] num_q, num_d;
  logic [6:0]  low_q, low_d;
  div_op_e     op_q, op_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;

  // Calendar registers.
  logic [15:0] days_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q;
  logic [2:0]  wday_q;
  logic [7:0]  year_q;
  logic [8:0]  yday_q;
  logic [3:0]  mon_q;
  logic        leap_q;

  logic                out_valid_q;
  logic [OutW-1:0]     out_q;

  logic [25:0] recip;
  logic [9:0]  den;
  logic [50:0] prod;
  logic [25:0] qden;
  logic [24:0] diff;
  logic        div_busy;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        year_done;
  logic        month_done;
  logic [15:0] wday_num;
  logic [4:0]  mday;

  // Reciprocal and reduced divisor of the running operation.
  always_comb begin
    unique case (op_q)
      OP_DAY: begin
        recip = RecipDay;
        den   = DenDay;
      end
      OP_MIN: begin
        recip = RecipMin;
        den   = DenSixty;
      end
      OP_HOUR: begin
        recip = RecipHour;
        den   = DenSixty;
      end
      OP_WDAY: begin
        recip = RecipWday;
        den   = DenWeek;
      end
      default: begin
        recip = RecipDay;
        den   = DenDay;
      end
    endcase
  end

  // The quotient comes from the product, the remainder in the next cycle.
  assign prod = num_q * recip;
  assign qden = quo_q * den;
  assign diff = num_q - qden[24:0];

  // Start of a division loads the reduced operand; then quotient, then remainder.
  always_comb begin
    wday_num = days_q + EpochWday;
    num_d    = num_q;
    low_d    = low_q;
    op_d     = op_q;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    if (cmd_i.div_start) begin
      op_d  = cmd_i.div_op;
      cnt_d = 2'd2;
      unique case (cmd_i.div_op)
        OP_DAY: begin
          num_d = in_data_i[31:7];
          low_d = in_data_i[6:0];
        end
        OP_MIN: begin
          num_d = {10'd0, rem_q[16:2]};
          low_d = {5'd0, rem_q[1:0]};
        end
        OP_HOUR: begin
          num_d = {16'd0, quo_q[10:2]};
          low_d = {5'd0, quo_q[1:0]};
        end
        OP_WDAY: begin
          num_d = {9'd0, wday_num};
          low_d = '0;
        end
        default: begin
          num_d = in_data_i[31:7];
          low_d = in_data_i[6:0];
        end
      endcase
    end else if (cnt_q == 2'd2) begin
      unique case (op_q) inside
        OP_DAY:          quo_d = prod[50:35];
        OP_HOUR:         quo_d = prod[28:13];
        OP_MIN, OP_WDAY: quo_d = prod[34:19];
        default:         quo_d = prod[34:19];
      endcase
      cnt_d = 2'd1;
    end else if (cnt_q == 2'd1) begin
      // The bypassed low bits rejoin the reduced remainder.
      unique case (op_q) inside
        OP_DAY:          rem_d = {diff[9:0], low_q};
        OP_WDAY:         rem_d = {14'd0, diff[2:0]};
        OP_MIN, OP_HOUR: rem_d = {11'd0, diff[3:0], low_q[1:0]};
        default:         rem_d = {11'd0, diff[3:0], low_q[1:0]};
      endcase
      cnt_d = 2'd0;
    end
  end

  assign div_busy = (cnt_q != 2'd0);

  // Year and month walk lengths.
  assign ylen       = year_len(is_leap(year_q));
  assign mlen       = month_len(leap_q, mon_q);
  assign year_done  = days_q < {7'd0, ylen};
  assign month_done = (mon_q == LastMonth) || (days_q < {11'd0, mlen});
  assign mday       = days_q[4:0] + 5'd1;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; division results are captured when the next division starts, the weekday's at year init.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    low_q <= low_d;
    op_q  <= op_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.div_start) begin
      unique case (cmd_i.div_op)
        OP_MIN:  days_q <= quo_q[15:0];
        OP_HOUR: sec_q  <= rem_q[5:0];
        OP_WDAY: begin
          min_q  <= rem_q[5:0];
          hour_q <= quo_q[4:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.year_init) begin
      wday_q <= rem_q[2:0];
      year_q <= EpochYear;
    end
    if (cmd_i.year_step && !year_done) begin
      days_q <= days_q - {7'd0, ylen};
      year_q <= year_q + 8'd1;
    end
    if (cmd_i.month_init) begin
      yday_q <= days_q[8:0];
      leap_q <= is_leap(year_q);
      mon_q  <= '0;
    end
    if (cmd_i.month_step && !month_done) begin
      days_q <= days_q - {11'd0, mlen};
      mon_q  <= mon_q + 4'd1;
    end
    if (cmd_i.out_load) begin
      out_q <= {2'd0, mday, mon_q, yday_q, year_q, wday_q, hour_q, min_q, sec_q};
    end
  end

  assign sts_o.div_done   = !div_busy;
  assign sts_o.year_done  = year_done;
  assign sts_o.month_done = month_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/e2c_ctrl.sv]
// Controller: sequences the divisions, the year walk, the month walk and the output load.
// Depends on e2c_pkg for the command and status structs.
module e2c_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  e2c_pkg::e2c_sts_t sts_i,
  output e2c_pkg::e2c_cmd_t cmd_o
);
  import e2c_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DIV_DAY  = 8'b0000_0010,
    ST_DIV_MIN  = 8'b0000_0100,
    ST_DIV_HOUR = 8'b0000_1000,
    ST_DIV_WDAY = 8'b0001_0000,
    ST_YEAR     = 8'b0010_0000,
    ST_MONTH    = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = OP_DAY;
          state_d         = ST_DIV_DAY;
        end
      end
      ST_DIV_DAY: begin
        if (sts_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = OP_MIN;
          state_d         = ST_DIV_MIN;
        end
      end
      ST_DIV_MIN: begin
        if (sts_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = OP_HOUR;
          state_d         = ST_DIV_HOUR;
        end
      end
      ST_DIV_HOUR: begin
        if (sts_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = OP_WDAY;
          state_d         = ST_DIV_WDAY;
        end
      end
      ST_DIV_WDAY: begin
        if (sts_i.div_done) begin
          cmd_o.year_init = 1'b1;
          state_d         = ST_YEAR;
        end
      end
      ST_YEAR: begin
        cmd_o.year_step = 1'b1;
        if (sts_i.year_done) begin
          cmd_o.month_init = 1'b1;
          state_d          = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (sts_i.month_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/epoch_seconds_to_calendar.sv]
// Epoch seconds to Gregorian calendar (UTC). One item at a time. Four constant divisions by
// reciprocal multiplication are followed by walks of one year or month per cycle, over
// 0 to 136 years and 0 to 11 months. A new item is taken once the previous result sits in
// the output register. Reset clears the controller, divider count and output valid.
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] epoch_seconds
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day, [19:17] weekday,
  // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month_index,
  // [45:41] day_of_month, [47:46] zero
  output logic [47:0] m_axis_tdata_o
);
  import e2c_pkg::*;

  e2c_cmd_t cmd;
  e2c_sts_t sts;

  e2c_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  e2c_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // After an input transfer the block is busy in the following cycle.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  // A result is never loaded over one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten");

  // Output valid only rises after a load command.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd.out_load))
    else $error("output valid without a result");

  // Presented time, weekday, month and day-of-month fields stay within their ranges.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[5:0] < 6'd60) && (m_axis_tdata_o[11:6] < 6'd60) &&
                        (m_axis_tdata_o[16:12] < 5'd24) && (m_axis_tdata_o[19:17] < 3'd7) &&
                        (m_axis_tdata_o[40:37] < 4'd12) && (m_axis_tdata_o[45:41] != 5'd0))
    else $error("calendar field out of range");

endmodule

[tb/tb_epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps
// Self-checking testbench for epoch_seconds_to_calendar: drives seconds counts over the input
// stream and checks every calendar result against a typed-in date or a predictor kept in this file.
// Depends on e2c_pkg and the top level epoch_seconds_to_calendar.
module tb_epoch_seconds_to_calendar;

  // One calendar result, laid out exactly as the output tdata (first member is the MSB).
  typedef struct packed {
    logic [1:0] spare;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [8:0] day_of_year;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } calendar_t;

  // A row of the directed table; the date is typed in only where known is set.
  typedef struct packed {
    logic [31:0] secs;
    logic        known;
    calendar_t   cal;
  } stim_row_t;

  localparam int unsigned NumDirected  = 17;
  localparam int unsigned NumRandom    = 1400;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned DrainCycles  = 300;
  localparam int unsigned SecsInDay    = 86400;

  localparam stim_row_t DirectedRows [NumDirected] = '{
    // epoch origin, a Thursday
    '{secs: 32'd0, known: 1'b1,
      cal: '{spare: 2'd0, day_of_month: 5'd1, month_index: 4'd0, day_of_year: 9'd0,
             years_since_1900: 8'd70, weekday: 3'd4, hour_of_day: 5'd0,
             minute_of_hour: 6'd0, second_of_minute: 6'd0}},
    // last second of the first day
    '{secs: 32'd86399, known: 1'b1,
      cal: '{spare: 2'd0, day_of_month: 5'd1, month_index: 4'd0, day_of_year: 9'd0,
             years_since_1900: 8'd70, weekday: 3'd4, hour_of_day: 5'd23,
             minute_of_hour: 6'd59, second_of_minute: 6'd59}},
    '{secs: 32'd86400,       known: 1'b0, cal: '0},
    // turn of the first year
    '{secs: 32'd31535999,    known: 1'b0, cal: '0},
    '{secs: 32'd31536000,    known: 1'b0, cal: '0},
    // leap day and last day of the first leap year
    '{secs: 32'd68169600,    known: 1'b0, cal: '0},
    '{secs: 32'd94694399,    known: 1'b0, cal: '0},
    // century year that is leap, divisible by 400
    '{secs: 32'd946684799,   known: 1'b0, cal: '0},
    '{secs: 32'd951782400,   known: 1'b0, cal: '0},
    '{secs: 32'd978307199,   known: 1'b0, cal: '0},
    // the signed 32-bit rollover point
    '{secs: 32'd2147483647,  known: 1'b0, cal: '0},
    '{secs: 32'd2147483648,  known: 1'b0, cal: '0},
    // century year that is not leap: February ends on the 28th
    '{secs: 32'd4107542399,  known: 1'b0, cal: '0},
    '{secs: 32'd4107542400,  known: 1'b0, cal: '0},
    // alternating bit patterns
    '{secs: 32'hAAAA_AAAA,   known: 1'b0, cal: '0},
    '{secs: 32'h5555_5555,   known: 1'b0, cal: '0},
    // largest count, a Sunday in February 2106
    '{secs: 32'hFFFF_FFFF, known: 1'b1,
      cal: '{spare: 2'd0, day_of_month: 5'd7, month_index: 4'd1, day_of_year: 9'd37,
             years_since_1900: 8'd206, weekday: 3'd0, hour_of_day: 5'd6,
             minute_of_hour: 6'd28, second_of_minute: 6'd15}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;    // [31:0] epoch_seconds
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day, [19:17] weekday,
  // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month_index,
  // [45:41] day_of_month, [47:46] zero
  logic [e2c_pkg::OutW-1:0] m_axis_tdata_o;

  calendar_t   pending_dates[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          calm;

  epoch_seconds_to_calendar uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Free-running clock, 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Gregorian leap rule on a full calendar year.
  function automatic bit gregorian_leap(input int unsigned year);
    return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned year,
                                                input int unsigned mon);
    case (mon) inside
      1:             return gregorian_leap(year) ? 29 : 28;
      3, 5, 8, 10:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Days from the epoch origin to the first of January of the given year.
  function automatic int unsigned days_to_year(input int unsigned year);
    int unsigned total;
    total = 0;
    for (int unsigned y = 1970; y < year; y++) total += gregorian_leap(y) ? 366 : 365;
    return total;
  endfunction

  // Works out the calendar date of a seconds count by walking years, then months.
  function automatic calendar_t convert_seconds(input logic [31:0] secs);
    calendar_t   cal;
    int unsigned days;
    int unsigned rem;
    int unsigned year;
    int unsigned mon;
    int unsigned ylen;
    days = secs / SecsInDay;
    rem  = secs % SecsInDay;
    cal  = '0;
    cal.second_of_minute = 6'(rem % 60);
    cal.minute_of_hour   = 6'((rem % 3600) / 60);
    cal.hour_of_day      = 5'(rem / 3600);
    cal.weekday          = 3'((days + 4) % 7);
    year = 1970;
    ylen = 365;
    while (days >= ylen) begin
      days -= ylen;
      year++;
      ylen = gregorian_leap(year) ? 366 : 365;
    end
    cal.years_since_1900 = 8'(year - 1900);
    cal.day_of_year      = 9'(days);
    mon = 0;
    while (mon < 11 && days >= days_in_month(year, mon)) begin
      days -= days_in_month(year, mon);
      mon++;
    end
    cal.month_index  = 4'(mon);
    cal.day_of_month = 5'(days + 1);
    return cal;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    if (roll < 98) return $urandom_range(5, 20);
    return $urandom_range(21, 80);
  endfunction

  // Random seconds count, biased towards year and month boundaries and the range ends.
  function automatic logic [31:0] pick_epoch();
    int unsigned kind;
    int unsigned year;
    int unsigned mon;
    longint      base;
    longint      offset;
    kind = $urandom_range(99);
    if (kind < 40) return $urandom();
    if (kind < 45) return $urandom_range(0, 200000);
    if (kind < 55) return 32'hFFFF_FFFF - $urandom_range(0, 50000000);
    // Leap-rule years are picked often so that their boundaries get real traffic.
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0:       year = 1972;
        1:       year = 2000;
        2:       year = 2096;
        3:       year = 2100;
        default: year = 2104;
      endcase
    end else begin
      year = $urandom_range(1971, 2106);
    end
    if (kind < 75) begin
      base   = longint'(days_to_year(year)) * SecsInDay;
      offset = longint'($urandom_range(345600)) - 172800;
    end else begin
      if (year > 2105) year = 2105;
      mon  = $urandom_range(1, 11);
      base = longint'(days_to_year(year));
      for (int unsigned m = 0; m < mon; m++) base += longint'(days_in_month(year, m));
      base   = base * SecsInDay;
      offset = longint'($urandom_range(172800)) - 86400;
    end
    return 32'(base + offset);
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_date(input calendar_t got, input calendar_t want);
    if (got.second_of_minute != want.second_of_minute)
      report_mismatch("second_of_minute", 32'(got.second_of_minute),
                      32'(want.second_of_minute));
    if (got.minute_of_hour != want.minute_of_hour)
      report_mismatch("minute_of_hour", 32'(got.minute_of_hour), 32'(want.minute_of_hour));
    if (got.hour_of_day != want.hour_of_day)
      report_mismatch("hour_of_day", 32'(got.hour_of_day), 32'(want.hour_of_day));
    if (got.weekday != want.weekday)
      report_mismatch("weekday", 32'(got.weekday), 32'(want.weekday));
    if (got.years_since_1900 != want.years_since_1900)
      report_mismatch("years_since_1900", 32'(got.years_since_1900),
                      32'(want.years_since_1900));
    if (got.day_of_year != want.day_of_year)
      report_mismatch("day_of_year", 32'(got.day_of_year), 32'(want.day_of_year));
    if (got.month_index != want.month_index)
      report_mismatch("month_index", 32'(got.month_index), 32'(want.month_index));
    if (got.day_of_month != want.day_of_month)
      report_mismatch("day_of_month", 32'(got.day_of_month), 32'(want.day_of_month));
    if (got.spare != want.spare)
      report_mismatch("padding bits", 32'(got.spare), 32'(want.spare));
  endtask

  // Offers one seconds count and waits for its transfer. The valid is only lowered when
  // a gap follows, so back-to-back items keep it high.
  task automatic send_seconds(input logic [31:0] secs, input logic known,
                              input calendar_t cal);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= secs;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_dates.push_back(known ? cal : convert_seconds(secs));
  endtask

  // Result side: each output transfer is checked against the oldest expected date.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, low word", m_axis_tdata_o[31:0], 0);
      end else begin
        check_date(calendar_t'(m_axis_tdata_o), pending_dates.pop_front());
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls of random length, with calm stretches where it never stalls.
  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
  end

  // Reset, directed table, random items, then drain and verdict.
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    calm            = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedRows[i])
      send_seconds(DirectedRows[i].secs, DirectedRows[i].known, DirectedRows[i].cal);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(3) == 0);
      // Halfway through, hold the sender until the block has delivered everything.
      if (n == NumRandom / 2) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk_i);
      end
      send_seconds(pick_epoch(), 1'b0, '0);
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[epoch_seconds_to_calendar.f]
design/e2c_pkg.sv
design/e2c_dpath.sv
design/e2c_ctrl.sv
design/epoch_seconds_to_calendar.sv
tb/tb_epoch_seconds_to_calendar.sv
